// ===== hdl/hbvp_pkg.sv =====
// Shared types, codes and constants for the hybrid bank victim placement unit.
// Depends on nothing; hbvp_front, hbvp_back and the top level import it.
package hbvp_pkg;

  // Default sizes, handed to the top level's parameters; QUEUE_DEPTH sets the queue depth.
  localparam int DEF_SETS       = 1024;
  localparam int DEF_WAYS       = 16;
  localparam int DEF_COUNT_BITS = 16;
  localparam int QUEUE_DEPTH    = 4;

  // Fixed field widths.
  localparam int SET_FIELD_W = 10;
  localparam int WAY_FIELD_W = 16;
  localparam int ADDR_W      = 48;
  localparam int MASK_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Write bucket select and bank preference constants.
  localparam int          BUCKET_LSB   = 6;
  localparam logic [2:0]  BUCKET_SEL   = 3'h7;
  localparam int          PCT_SCALE    = 100;
  localparam logic [6:0]  PCT_MAX      = 7'd100;
  localparam logic [3:0]  MIN_DISTINCT = 4'd2;

  // Opcodes.
  localparam logic [1:0] OP_HIT   = 2'd0;
  localparam logic [1:0] OP_FILL  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRAM_WAYS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_WIN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PCT_THRESH  = 2'd3;

  // Configuration reset values.
  localparam logic        RST_POLICY_MODE = 1'b1;
  localparam logic [4:0]  RST_SRAM_WAYS   = 5'd4;
  localparam logic [15:0] RST_DECAY_WIN   = 16'd0;
  localparam logic [6:0]  RST_PCT_THRESH  = 7'd50;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [SET_FIELD_W-1:0] set_index;
    logic                   is_write;
    logic [ADDR_W-1:0]      address;
    logic [WAY_FIELD_W-1:0] allowed_ways;
    logic [WAY_FIELD_W-1:0] valid_ways;
  } in_item_t;

  typedef struct packed {
    logic                   no_candidate;
    logic                   prefer_sram;
    logic                   free_way_found;
    logic [3:0]             free_way;
    logic [WAY_FIELD_W-1:0] policy_mask;
  } out_item_t;

  typedef struct packed {
    logic        policy_mode;
    logic [4:0]  sram_way_count;
    logic [15:0] decay_window;
    logic [6:0]  write_pct_threshold;
  } cfg_t;

  typedef enum logic {
    KIND_UPDATE = 1'b0,
    KIND_QUERY  = 1'b1
  } item_kind_t;

  // Classified item as it travels from the front to the back.
  typedef struct packed {
    item_kind_t             kind;
    logic [SET_FIELD_W-1:0] set_raw;
    logic [SET_FIELD_W-1:0] set_quot;
    logic                   is_write;
    logic [2:0]             bucket;
    logic [WAY_FIELD_W-1:0] cand;
    logic [WAY_FIELD_W-1:0] invalid;
  } queue_entry_t;

  // Ways that exist, seen through the 16-bit way fields.
  function automatic logic [WAY_FIELD_W-1:0] way_all_mask(input int ways);
    logic [32:0] full;
    full = (33'd1 << ways) - 33'd1;
    return full[WAY_FIELD_W-1:0];
  endfunction

endpackage

// ===== hdl/hbvp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hbvp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/hbvp_queue.sv =====
// Short flop-based FIFO between the front and the back.
// No package dependencies; payload is a flat vector.
module hbvp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/hbvp_front.sv =====
// Front end: accept items, decode and classify them, push them into the queue.
// Depends on hbvp_pkg.
module hbvp_front #(
  parameter int SETS = hbvp_pkg::DEF_SETS,
  parameter int WAYS = hbvp_pkg::DEF_WAYS
) (
  input  logic                    in_valid,
  output logic                    in_ready,
  input  hbvp_pkg::in_item_t      in_data,
  input  logic                    clearing,
  input  logic                    queue_full,
  output logic                    push,
  output hbvp_pkg::queue_entry_t  push_data
);

  import hbvp_pkg::*;

  // Exact reciprocal for set_index / SETS over all 10-bit indexes.
  localparam int DIV_K  = SET_FIELD_W + $clog2(SETS);
  localparam longint RECIP_L = ((64'd1 << DIV_K) + longint'(SETS) - 64'd1) / longint'(SETS);
  localparam int PROD_W = SET_FIELD_W + DIV_K + 1;
  localparam logic [PROD_W-1:0] RECIP = PROD_W'(RECIP_L);
  localparam logic [WAY_FIELD_W-1:0] WAY_ALL = way_all_mask(WAYS);

  logic [PROD_W-1:0]      quot_prod;
  logic [WAY_FIELD_W-1:0] cand;
  logic                   is_update;
  logic                   is_query;

  assign in_ready  = !clearing && !queue_full;
  assign quot_prod = PROD_W'(in_data.set_index) * RECIP;
  assign cand      = in_data.allowed_ways & WAY_ALL;
  assign is_update = (in_data.opcode == OP_HIT) || (in_data.opcode == OP_FILL);
  assign is_query  = (in_data.opcode == OP_QUERY);

  // Drop the unused opcode: accepted, never queued.
  assign push = in_valid && in_ready && (is_update || is_query);

  always_comb begin
    push_data.kind     = is_query ? KIND_QUERY : KIND_UPDATE;
    push_data.set_raw  = in_data.set_index;
    push_data.set_quot = quot_prod[DIV_K +: SET_FIELD_W];
    push_data.is_write = in_data.is_write;
    push_data.bucket   = in_data.address[BUCKET_LSB +: 3] & BUCKET_SEL;
    push_data.cand     = cand;
    push_data.invalid  = cand & ~in_data.valid_ways;
  end

endmodule

// ===== hdl/hbvp_back.sv =====
// Back end: per-set counter table, read-modify-write of counters, victim choice.
// Depends on hbvp_pkg and hbvp_ram.
module hbvp_back #(
  parameter int SETS       = hbvp_pkg::DEF_SETS,
  parameter int WAYS       = hbvp_pkg::DEF_WAYS,
  parameter int COUNT_BITS = hbvp_pkg::DEF_COUNT_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  hbvp_pkg::cfg_t          cfg,
  input  logic                    queue_empty,
  input  hbvp_pkg::queue_entry_t  queue_data,
  output logic                    pop,
  output logic                    clearing,
  output logic                    out_valid,
  input  logic                    out_ready,
  output hbvp_pkg::out_item_t     out_data
);

  import hbvp_pkg::*;

  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WORD_W = 2 * COUNT_BITS + MASK_W;
  localparam int PROD_W = COUNT_BITS + 7;
  localparam int QD_W   = SET_FIELD_W + 17;
  localparam logic [WAY_FIELD_W-1:0] WAY_ALL = way_all_mask(WAYS);
  localparam logic [COUNT_BITS-1:0]  CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_READ   = 6'b000100,
    ST_UPDATE = 6'b001000,
    ST_MULT   = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  function automatic logic [3:0] lowest_way(input logic [WAY_FIELD_W-1:0] m);
    logic [3:0] idx;
    idx = '0;
    for (int i = WAY_FIELD_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = 4'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [3:0] pop8(input logic [MASK_W-1:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < MASK_W; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  state_t state;
  state_t state_next;

  logic [SET_W-1:0] clr_cnt;

  // Item under work.
  queue_entry_t     item;
  logic [SET_W-1:0] item_idx;

  // Registered products and flags for the bank decision.
  logic [PROD_W-1:0] wr_scaled;
  logic [PROD_W-1:0] thr_scaled;
  logic              touch_nz;
  logic              multi_bucket;

  // Table port.
  logic              ram_we;
  logic [SET_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [WORD_W-1:0] ram_rdata;

  logic [COUNT_BITS-1:0] rd_touch;
  logic [COUNT_BITS-1:0] rd_write;
  logic [MASK_W-1:0]     rd_mask;

  logic [QD_W-1:0]       quot_times;
  logic [QD_W-1:0]       set_rem;
  logic [COUNT_BITS-1:0] t_inc;
  logic [COUNT_BITS:0]   t_round;
  logic [COUNT_BITS-1:0] w_inc;
  logic [MASK_W-1:0]     m_set;
  logic                  decay;
  logic [WORD_W-1:0]     upd_word;

  logic [6:0]             thr_eff;
  logic [5:0]             sram_eff;
  logic [32:0]            sram_full;
  logic [WAY_FIELD_W-1:0] sram_bank;
  logic                   pick;
  logic [WAY_FIELD_W-1:0] bank;
  logic [WAY_FIELD_W-1:0] inv_bank;
  logic [WAY_FIELD_W-1:0] sub_mask;
  out_item_t              result;
  logic                   emit_go;

  hbvp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SETS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (item_idx),
    .rdata (ram_rdata)
  );

  assign {rd_touch, rd_write, rd_mask} = ram_rdata;

  // Remainder of the set index, quotient taken in the front.
  assign quot_times = QD_W'(queue_data.set_quot) * QD_W'(SETS);
  assign set_rem    = QD_W'(queue_data.set_raw) - quot_times;

  assign clearing = (state == ST_CLEAR);
  assign pop      = (state == ST_IDLE) && !queue_empty;
  assign ram_re   = (state == ST_READ);
  assign emit_go  = (state == ST_EMIT) && (!out_valid || out_ready);

  // Counter update with saturation and halving decay.
  always_comb begin
    t_inc = (rd_touch == CNT_MAX) ? rd_touch : rd_touch + COUNT_BITS'(1);
    w_inc = rd_write;
    m_set = rd_mask;
    if (item.is_write) begin
      w_inc = (rd_write == CNT_MAX) ? rd_write : rd_write + COUNT_BITS'(1);
      m_set = rd_mask | (MASK_W'(1) << item.bucket);
    end
    decay   = (cfg.decay_window != '0) && (32'(t_inc) >= 32'(cfg.decay_window));
    t_round = {1'b0, t_inc} + (COUNT_BITS + 1)'(1);
    if (decay) begin
      upd_word = {t_round[COUNT_BITS:1], w_inc >> 1, m_set >> 1};
    end else begin
      upd_word = {t_inc, w_inc, m_set};
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = item_idx;
    ram_wdata = upd_word;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else if (state == ST_UPDATE) begin
      ram_we = 1'b1;
    end
  end

  // Bank choice and victim selection.
  always_comb begin
    thr_eff   = (cfg.write_pct_threshold > PCT_MAX) ? PCT_MAX : cfg.write_pct_threshold;
    sram_eff  = (6'(cfg.sram_way_count) > 6'(WAYS)) ? 6'(WAYS) : 6'(cfg.sram_way_count);
    sram_full = (33'd1 << sram_eff) - 33'd1;
    sram_bank = sram_full[WAY_FIELD_W-1:0];
    if (sram_eff == '0) begin
      pick = 1'b0;
    end else if (cfg.policy_mode == 1'b0) begin
      pick = touch_nz && (wr_scaled >= thr_scaled);
    end else begin
      pick = multi_bucket;
    end
    bank     = pick ? sram_bank : (WAY_ALL & ~sram_bank);
    inv_bank = item.invalid & bank;
    sub_mask = ((item.cand & bank) != '0) ? (item.cand & bank) : item.cand;

    result = '0;
    if (item.cand == '0) begin
      result.no_candidate = 1'b1;
    end else begin
      result.prefer_sram = pick;
      if (item.invalid != '0) begin
        result.free_way_found = 1'b1;
        result.free_way = (inv_bank != '0) ? lowest_way(inv_bank) : lowest_way(item.invalid);
      end else begin
        result.policy_mask = sub_mask;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == SET_W'(SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!queue_empty) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = (item.kind == KIND_QUERY) ? ST_MULT : ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = ST_IDLE;
      end
      ST_MULT: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + SET_W'(1);
      end
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item     <= queue_data;
      item_idx <= set_rem[SET_W-1:0];
    end
    if (state == ST_MULT) begin
      wr_scaled    <= PROD_W'(rd_write) * PROD_W'(PCT_SCALE);
      thr_scaled   <= PROD_W'(thr_eff) * PROD_W'(rd_touch);
      touch_nz     <= (rd_touch != '0);
      multi_bucket <= (pop8(rd_mask) >= MIN_DISTINCT);
    end
    if (emit_go) begin
      out_data <= result;
    end
  end

endmodule

// ===== hdl/hybrid_bank_victim_placement_unit.sv =====
// Flow: a hit or fill goes through the back end's IDLE, READ and UPDATE states;
//   a query goes through IDLE, READ, MULT and EMIT, waits in EMIT until the output
//   register is free, then registers its result. The back end finishes each item's
//   read-modify-write of the per-set counter RAM before it pops the next; a 4-entry
//   queue absorbs bursts at the input. Opcode 3 is taken and dropped at once.
// Reset: config returns to defaults, then a clearing pass zeroes all SETS entries
//   of the counter table (1024 by default) with in_ready held low.
module hybrid_bank_victim_placement_unit #(
  parameter int SETS       = hbvp_pkg::DEF_SETS,
  parameter int WAYS       = hbvp_pkg::DEF_WAYS,
  parameter int COUNT_BITS = hbvp_pkg::DEF_COUNT_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  hbvp_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output hbvp_pkg::out_item_t                    out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [hbvp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hbvp_pkg::CFG_DATA_W-1:0]        cfg_data
);

  import hbvp_pkg::*;

  localparam int ENTRY_W = $bits(queue_entry_t);

  cfg_t         cfg;
  logic         clearing;
  logic         queue_full;
  logic         queue_empty;
  logic         push;
  logic         pop;
  queue_entry_t push_data;
  queue_entry_t pop_data;
  logic [ENTRY_W-1:0] pop_bits;

  // Configuration writes are always taken; software writes only while idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.policy_mode         <= RST_POLICY_MODE;
      cfg.sram_way_count      <= RST_SRAM_WAYS;
      cfg.decay_window        <= RST_DECAY_WIN;
      cfg.write_pct_threshold <= RST_PCT_THRESH;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POLICY_MODE: cfg.policy_mode         <= cfg_data[0];
        REG_SRAM_WAYS:   cfg.sram_way_count      <= cfg_data[4:0];
        REG_DECAY_WIN:   cfg.decay_window        <= cfg_data[15:0];
        REG_PCT_THRESH:  cfg.write_pct_threshold <= cfg_data[6:0];
        default:         cfg <= cfg;
      endcase
    end
  end

  // Front: take each transfer, compute the set quotient and way masks.
  hbvp_front #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .clearing   (clearing),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  // Queue: decouple the front from the back so each can stall on its own.
  hbvp_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_bits),
    .empty     (queue_empty)
  );

  assign pop_data = queue_entry_t'(pop_bits);

  // Back: update counters per set or resolve a victim query into the
  // output register, which holds the result until its transfer.
  hbvp_back #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .queue_empty (queue_empty),
    .queue_data  (pop_data),
    .pop         (pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
